### design/mk_pkg.sv
`timescale 1ns / 1ps

package mk_pkg;

    localparam int SYMBOL_COUNT_DEF = 40;
    localparam int MAX_ELEMENTS_DEF = 6;

    localparam logic [7:0] WPM_RESET   = 8'd12;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [2:0] GAP_ELEMENT = 3'd1;
    localparam logic [2:0] GAP_LETTER  = 3'd3;
    localparam logic [2:0] GAP_WORD    = 3'd7;
    localparam logic [2:0] DIT_UNITS   = 3'd1;
    localparam logic [2:0] DAH_UNITS   = 3'd3;

    localparam int SYM_IDX_W = 6;
    localparam int CODE_W    = 6;
    localparam int CNT_W     = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GAP,
        ST_MARK,
        ST_DRAIN
    } seq_state_t;

    typedef struct packed {
        logic       hit;
        logic [SYM_IDX_W-1:0] idx;
    } sym_hit_t;

    typedef struct packed {
        logic [2:0]        len;
        logic [CODE_W-1:0] code;
    } sym_code_t;

    // one run handed from the sequencer to the run unit
    typedef struct packed {
        logic       emit;
        logic       clear;
        logic       key;
        logic [2:0] units;
        logic       last;
    } run_req_t;

    function automatic sym_hit_t char_to_sym(input logic [7:0] c);
        sym_hit_t r;
        r.hit = 1'b1;
        r.idx = '0;
        case (c) inside
            [8'h41:8'h5a]: r.idx = SYM_IDX_W'(c - 8'h41);
            [8'h30:8'h39]: r.idx = SYM_IDX_W'(c - 8'h30 + 8'd26);
            8'h2f:         r.idx = SYM_IDX_W'(36);
            8'h3f:         r.idx = SYM_IDX_W'(37);
            8'h2e:         r.idx = SYM_IDX_W'(38);
            8'h2c:         r.idx = SYM_IDX_W'(39);
            default:       r.hit = 1'b0;
        endcase
        return r;
    endfunction

    // code left-aligned, first element in the top bit, 1 = dah
    function automatic sym_code_t sym_code(input logic [SYM_IDX_W-1:0] idx);
        sym_code_t r;
        case (idx)
            6'd0:    r = '{3'd2, 6'b010000};
            6'd1:    r = '{3'd4, 6'b100000};
            6'd2:    r = '{3'd4, 6'b101000};
            6'd3:    r = '{3'd3, 6'b100000};
            6'd4:    r = '{3'd1, 6'b000000};
            6'd5:    r = '{3'd4, 6'b001000};
            6'd6:    r = '{3'd3, 6'b110000};
            6'd7:    r = '{3'd4, 6'b000000};
            6'd8:    r = '{3'd2, 6'b000000};
            6'd9:    r = '{3'd4, 6'b011100};
            6'd10:   r = '{3'd3, 6'b101000};
            6'd11:   r = '{3'd4, 6'b010000};
            6'd12:   r = '{3'd2, 6'b110000};
            6'd13:   r = '{3'd2, 6'b100000};
            6'd14:   r = '{3'd3, 6'b111000};
            6'd15:   r = '{3'd4, 6'b011000};
            6'd16:   r = '{3'd4, 6'b110100};
            6'd17:   r = '{3'd3, 6'b010000};
            6'd18:   r = '{3'd3, 6'b000000};
            6'd19:   r = '{3'd1, 6'b100000};
            6'd20:   r = '{3'd3, 6'b001000};
            6'd21:   r = '{3'd4, 6'b000100};
            6'd22:   r = '{3'd3, 6'b011000};
            6'd23:   r = '{3'd4, 6'b100100};
            6'd24:   r = '{3'd4, 6'b101100};
            6'd25:   r = '{3'd4, 6'b110000};
            6'd26:   r = '{3'd5, 6'b111110};
            6'd27:   r = '{3'd5, 6'b011110};
            6'd28:   r = '{3'd5, 6'b001110};
            6'd29:   r = '{3'd5, 6'b000110};
            6'd30:   r = '{3'd5, 6'b000010};
            6'd31:   r = '{3'd5, 6'b000000};
            6'd32:   r = '{3'd5, 6'b100000};
            6'd33:   r = '{3'd5, 6'b110000};
            6'd34:   r = '{3'd5, 6'b111000};
            6'd35:   r = '{3'd5, 6'b111100};
            6'd36:   r = '{3'd5, 6'b100100};
            6'd37:   r = '{3'd6, 6'b001100};
            6'd38:   r = '{3'd6, 6'b010101};
            6'd39:   r = '{3'd6, 6'b110011};
            default: r = '{3'd0, 6'b000000};
        endcase
        return r;
    endfunction

    // dit length in ms, 1200 / wpm; out-of-range speeds run at 12 wpm
    function automatic logic [7:0] dit_ms(input logic [7:0] wpm);
        logic [7:0] r;
        case (wpm)
            8'd5:    r = 8'd240;
            8'd6:    r = 8'd200;
            8'd7:    r = 8'd171;
            8'd8:    r = 8'd150;
            8'd9:    r = 8'd133;
            8'd10:   r = 8'd120;
            8'd11:   r = 8'd109;
            8'd12:   r = 8'd100;
            8'd13:   r = 8'd92;
            8'd14:   r = 8'd85;
            8'd15:   r = 8'd80;
            8'd16:   r = 8'd75;
            8'd17:   r = 8'd70;
            8'd18:   r = 8'd66;
            8'd19:   r = 8'd63;
            8'd20:   r = 8'd60;
            default: r = 8'd100;
        endcase
        return r;
    endfunction

endpackage

### design/morse_keyer_core.sv
`timescale 1ns / 1ps

// channel   direction  handshake             payload
// input     in         in_valid / in_ready   ch, msg_first, msg_last
// result    out        out_valid / out_ready key_down, run_units, run_ms, unit_total, run_last
// config    in         cfg_we                cfg_data (words per minute)
//
// a character is accepted, then the sequencer steps through a gap and a mark per element,
// and through a final drain at the end of a message, stepping the run unit a single run
// per cycle, while the output is not stalled, through the one-item output register.
// reset clears speed to 12 wpm, the pending gap and the unit count.
// a stalled output holds the sequencer while it has a run to hand on; input is taken only when the sequencer is idle.

module morse_keyer_core #(
    parameter int SYMBOL_COUNT = mk_pkg::SYMBOL_COUNT_DEF,
    parameter int MAX_ELEMENTS = mk_pkg::MAX_ELEMENTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    input  logic        msg_first,
    input  logic        msg_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        key_down,
    output logic [2:0]  run_units,
    output logic [10:0] run_ms,
    output logic [15:0] unit_total,
    output logic        run_last
);
    import mk_pkg::*;

    logic [7:0] wpm_reg, wpm_next;
    logic [7:0] dit;
    logic       run_free;
    run_req_t   req;

    assign wpm_next = cfg_we ? cfg_data : wpm_reg;
    assign dit      = dit_ms(wpm_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wpm_reg <= WPM_RESET;
        else
            wpm_reg <= wpm_next;
    end

    mk_sequencer #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .ch        (ch),
        .msg_first (msg_first),
        .msg_last  (msg_last),
        .run_free  (run_free),
        .req       (req)
    );

    mk_run_unit u_run (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .dit        (dit),
        .run_free   (run_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .key_down   (key_down),
        .run_units  (run_units),
        .run_ms     (run_ms),
        .unit_total (unit_total),
        .run_last   (run_last)
    );

endmodule

### design/mk_sequencer.sv
`timescale 1ns / 1ps

module mk_sequencer #(
    parameter int SYMBOL_COUNT = mk_pkg::SYMBOL_COUNT_DEF,
    parameter int MAX_ELEMENTS = mk_pkg::MAX_ELEMENTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        ch,
    input  logic              msg_first,
    input  logic              msg_last,
    input  logic              run_free,
    output mk_pkg::run_req_t  req
);
    import mk_pkg::*;

    seq_state_t state_reg, state_next;
    logic [2:0]        pend_reg, pend_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              last_reg, last_next;

    logic       accept;
    logic       is_space;
    logic       sym_ok;
    logic       final_elem;
    logic [2:0] pend_base;
    sym_hit_t   hit;
    sym_code_t  sc;
    logic [CNT_W-1:0] len_ext;

    assign accept     = in_valid && (state_reg == ST_IDLE);
    assign is_space   = (ch == CHAR_SPACE);
    assign hit        = char_to_sym(ch);
    assign sc         = sym_code(hit.idx);
    assign sym_ok     = hit.hit && ({1'b0, hit.idx} < (SYM_IDX_W+1)'(SYMBOL_COUNT));
    assign pend_base  = msg_first ? 3'd0 : pend_reg;
    assign final_elem = (cnt_reg == CNT_W'(1));
    assign len_ext    = CNT_W'(sc.len);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!is_space && sym_ok)
                        state_next = ST_GAP;
                    else if (msg_last)
                        state_next = ST_DRAIN;
                end
            end
            ST_GAP:
            begin
                if (pend_reg == 3'd0 || run_free)
                    state_next = ST_MARK;
            end
            ST_MARK:
            begin
                if (run_free)
                begin
                    if (!final_elem)
                        state_next = ST_GAP;
                    else if (last_reg)
                        state_next = ST_DRAIN;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_DRAIN:
            begin
                if (pend_reg == 3'd0 || run_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        req       = '0;
        pend_next = pend_reg;
        code_next = code_reg;
        cnt_next  = cnt_reg;
        last_next = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    req.clear = msg_first;
                    last_next = msg_last;
                    if (is_space)
                        pend_next = GAP_WORD;
                    else
                        pend_next = pend_base;
                    code_next = sc.code;
                    // element count clipped to the configured maximum
                    cnt_next  = (len_ext > CNT_W'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS)
                                                                : len_ext;
                end
            end
            ST_GAP:
            begin
                if (pend_reg != 3'd0 && run_free)
                begin
                    req.emit  = 1'b1;
                    req.key   = 1'b0;
                    req.units = pend_reg;
                    pend_next = 3'd0;
                end
            end
            ST_MARK:
            begin
                if (run_free)
                begin
                    req.emit  = 1'b1;
                    req.key   = 1'b1;
                    req.units = code_reg[CODE_W-1] ? DAH_UNITS : DIT_UNITS;
                    req.last  = final_elem && !last_reg;
                    code_next = {code_reg[CODE_W-2:0], 1'b0};
                    cnt_next  = cnt_reg - CNT_W'(1);
                    pend_next = final_elem ? GAP_LETTER : GAP_ELEMENT;
                end
            end
            ST_DRAIN:
            begin
                if (pend_reg != 3'd0 && run_free)
                begin
                    req.emit  = 1'b1;
                    req.key   = 1'b0;
                    req.units = pend_reg;
                    req.last  = 1'b1;
                    pend_next = 3'd0;
                end
                else if (pend_reg == 3'd0)
                    pend_next = 3'd0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        cnt_reg  <= cnt_next;
        last_reg <= last_next;
    end

endmodule

### design/mk_run_unit.sv
`timescale 1ns / 1ps

module mk_run_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  mk_pkg::run_req_t  req,
    input  logic [7:0]        dit,
    output logic              run_free,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              key_down,
    output logic [2:0]        run_units,
    output logic [10:0]       run_ms,
    output logic [15:0]       unit_total,
    output logic              run_last
);
    import mk_pkg::*;

    logic        valid_reg, valid_next;
    logic [15:0] sent_reg, sent_next;
    logic        key_reg;
    logic [2:0]  units_reg;
    logic [10:0] ms_reg;
    logic [15:0] total_reg;
    logic        last_reg;

    logic [16:0] sum;
    logic [15:0] sat_sum;

    assign run_free = !valid_reg || out_ready;
    assign sum      = {1'b0, sent_reg} + 17'(req.units);
    assign sat_sum  = sum[16] ? 16'hffff : sum[15:0];

    always_comb
    begin
        valid_next = valid_reg;
        sent_next  = sent_reg;
        if (out_ready)
            valid_next = 1'b0;
        if (req.emit)
        begin
            valid_next = 1'b1;
            sent_next  = sat_sum;
        end
        else if (req.clear)
            sent_next = 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sent_reg  <= 16'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            sent_reg  <= sent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.emit)
        begin
            key_reg   <= req.key;
            units_reg <= req.units;
            ms_reg    <= 11'(req.units) * 11'(dit);
            total_reg <= sat_sum;
            last_reg  <= req.last;
        end
    end

    assign out_valid  = valid_reg;
    assign key_down   = key_reg;
    assign run_units  = units_reg;
    assign run_ms     = ms_reg;
    assign unit_total = total_reg;
    assign run_last   = last_reg;

endmodule
